>>> hw/rtl/dual_rate_motion_report_scheduler_macros.svh
// Assertion macros for the motion report scheduler.
// Bodies name clk and rst of the module that uses them.
`ifndef DUAL_RATE_MOTION_REPORT_SCHEDULER_MACROS_SVH
`define DUAL_RATE_MOTION_REPORT_SCHEDULER_MACROS_SVH

// Same-cycle implication.
`define DRMRS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define DRMRS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/drmrs_pkg.sv
// Package for the motion report scheduler: payload structs, state codes,
// register indexes, fixed-point constants and the round/saturate helper.
package drmrs_pkg;

  localparam int unsigned MIN_RATE_DEF = 10;
  localparam int unsigned MAX_RATE_DEF = 250;

  localparam int unsigned TW   = 48;   // time width
  localparam int unsigned PW   = 20;   // period / divisor width
  localparam int unsigned PNW  = 20;   // bits in the period numerator
  localparam int unsigned CNTW = 6;    // divider step counter width

  localparam logic [TW-1:0] PERIOD_NUM_ALIGNED = TW'(1000000) << (TW - PNW);

  localparam logic [21:0] RAD_Q16  = 22'd3754936;
  localparam logic [19:0] GRAV_Q16 = 20'd642689;

  localparam logic KIND_GYRO  = 1'b0;
  localparam logic KIND_ACCEL = 1'b1;

  localparam logic [2:0] REG_GYRO_ENABLE  = 3'd0;
  localparam logic [2:0] REG_ACCEL_ENABLE = 3'd1;
  localparam logic [2:0] REG_GYRO_RATE    = 3'd2;
  localparam logic [2:0] REG_ACCEL_RATE   = 3'd3;
  localparam logic [2:0] REG_SCALE_X      = 3'd4;
  localparam logic [2:0] REG_SCALE_Y      = 3'd5;

  typedef struct packed {
    logic [47:0]        now_us;
    logic               sample_ok;
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;
    logic signed [15:0] gyro_z;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
  } sample_t;

  typedef struct packed {
    logic               report_kind;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic [31:0]        report_count;
    logic               last_report;
  } report_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHAN,
    ST_PDIV,
    ST_RDIV,
    ST_MUL,
    ST_ACC,
    ST_OUT,
    ST_NEXT
  } state_t;

  // Round to nearest (ties away from zero) by 16 or 28 bits, then saturate.
  function automatic logic [31:0] round_sat(input logic signed [56:0] p,
                                            input logic sh28);
    logic        neg;
    logic [56:0] mag;
    logic [56:0] rnd;
    logic [56:0] shd;
    neg = p[56];
    mag = neg ? (~p + 57'd1) : p;
    rnd = mag + (sh28 ? (57'd1 << 27) : (57'd1 << 15));
    shd = sh28 ? (rnd >> 28) : (rnd >> 16);
    if (neg) begin
      if (shd > 57'h0_8000_0000) round_sat = 32'h8000_0000;
      else round_sat = 32'(~shd + 57'd1);
    end else begin
      if (shd > 57'h0_7FFF_FFFF) round_sat = 32'h7FFF_FFFF;
      else round_sat = shd[31:0];
    end
  endfunction

endpackage

>>> hw/rtl/dual_rate_motion_report_scheduler.sv
// Dual-rate motion report scheduler: top level, single module.
// Uses drmrs_pkg and dual_rate_motion_report_scheduler_macros.svh.
//
// Each accepted sample transaction is checked against one deadline per
// channel (gyro first, then accelerometer). A due channel gets its period
// (1000000 / clamped rate) and, when its deadline has passed, the catch-up
// remainder, both from one shared restoring divider that retires one bit per
// cycle; a valid sample then yields a scaled, saturated report built by one
// shared 33x24 multiplier. From its acceptance, a sample passes an accept
// step and then, per channel, a channel check; a due channel adds the period
// division, the remainder division (only when the deadline has passed) and,
// for a valid sample, a multiply and an accumulate step per multiply (5 gyro,
// 3 accel) and the report transaction, which a stall holds; a step to the
// next channel ends each channel. The block takes no sample while an item
// is in work; configuration writes are always ready, and any write to a
// defined register clears both deadlines.
`include "dual_rate_motion_report_scheduler_macros.svh"

module dual_rate_motion_report_scheduler
  import drmrs_pkg::*;
#(
  parameter int unsigned MIN_RATE = MIN_RATE_DEF,
  parameter int unsigned MAX_RATE = MAX_RATE_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        sample_valid,
  output logic        sample_stall,
  input  sample_t     sample,
  output logic        report_valid,
  input  logic        report_stall,
  output report_t     report,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  // Configuration registers.
  logic        gyro_enable, accel_enable;
  logic [15:0] gyro_rps, accel_rps, scale_x, scale_y;

  // Channel state.
  logic [TW-1:0] gdl, adl;
  logic [31:0]   gcnt, acnt;

  // Item in work.
  state_t  state, state_next;
  sample_t smp;
  logic    g_due, a_due;
  logic    ch;
  logic [PW-1:0] per;

  // Shared divider.
  logic [TW-1:0]   div_d;
  logic [PW-1:0]   div_rem, div_div, div_q;
  logic [CNTW-1:0] div_cnt;
  logic [PW:0]     trial;
  logic            trial_ge;
  logic [PW-1:0]   rem_next, q_next, per_next;

  // Shared multiplier.
  logic [2:0]          mstep;
  logic signed [32:0]  mul_a, t_reg;
  logic signed [23:0]  mul_b;
  logic signed [56:0]  p_reg;
  logic [31:0]         rx, ry, rz;
  logic [2:0]          last_step;

  // Current channel view.
  logic          cur_due;
  logic [TW-1:0] cur_dl;
  logic [15:0]   cur_rate, clamped;
  logic          cur_late;

  assign cur_due  = ch ? a_due : g_due;
  assign cur_dl   = ch ? adl : gdl;
  assign cur_rate = ch ? accel_rps : gyro_rps;
  assign cur_late = (cur_dl != '0) && (cur_dl <= smp.now_us);
  assign last_step = (ch == KIND_GYRO) ? 3'd4 : 3'd2;

  // Clamp: below minimum first, then above maximum.
  always_comb begin
    if (cur_rate < 16'(MIN_RATE)) clamped = 16'(MIN_RATE);
    else if (cur_rate > 16'(MAX_RATE)) clamped = 16'(MAX_RATE);
    else clamped = cur_rate;
  end

  // One restoring-division step: shift in the next dividend bit.
  assign trial    = {div_rem, div_d[TW-1]};
  assign trial_ge = trial >= {1'b0, div_div};
  assign rem_next = trial_ge ? PW'(trial - {1'b0, div_div}) : trial[PW-1:0];
  assign q_next   = {div_q[PW-2:0], trial_ge};
  assign per_next = (q_next == '0) ? PW'(1) : q_next;

  // Multiplier operand select by channel and step.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (ch == KIND_GYRO) begin
      case (mstep)
        3'd0: begin
          mul_a = {{17{smp.gyro_x[15]}}, smp.gyro_x};
          mul_b = {8'd0, scale_y};
        end
        3'd1: begin
          mul_a = t_reg;
          mul_b = {2'd0, RAD_Q16};
        end
        3'd2: begin
          mul_a = {{17{smp.gyro_y[15]}}, smp.gyro_y};
          mul_b = {8'd0, scale_x};
        end
        3'd3: begin
          mul_a = t_reg;
          mul_b = {2'd0, RAD_Q16};
        end
        default: begin
          mul_a = {{17{smp.gyro_z[15]}}, smp.gyro_z};
          mul_b = {2'd0, RAD_Q16};
        end
      endcase
    end else begin
      mul_b = {4'd0, GRAV_Q16};
      case (mstep)
        3'd0:    mul_a = {{17{smp.accel_x[15]}}, smp.accel_x};
        3'd1:    mul_a = {{17{smp.accel_y[15]}}, smp.accel_y};
        default: mul_a = {{17{smp.accel_z[15]}}, smp.accel_z};
      endcase
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (sample_valid) state_next = ST_CHAN;
      ST_CHAN: state_next = cur_due ? ST_PDIV : ST_NEXT;
      ST_PDIV: begin
        if (div_cnt == CNTW'(1)) begin
          if (cur_late) state_next = ST_RDIV;
          else state_next = smp.sample_ok ? ST_MUL : ST_NEXT;
        end
      end
      ST_RDIV: begin
        if (div_cnt == CNTW'(1)) state_next = smp.sample_ok ? ST_MUL : ST_NEXT;
      end
      ST_MUL: state_next = ST_ACC;
      ST_ACC: state_next = (mstep == last_step) ? ST_OUT : ST_MUL;
      ST_OUT: if (!report_stall) state_next = ST_NEXT;
      ST_NEXT: state_next = (ch == KIND_GYRO) ? ST_CHAN : ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    sample_stall = 1'b1;
    report_valid = 1'b0;
    unique case (state)
      ST_IDLE: sample_stall = 1'b0;
      ST_OUT:  report_valid = 1'b1;
      default: ;
    endcase
  end

  assign cfg_ready = 1'b1;

  // Report payload straight from registers.
  always_comb begin
    report.report_kind  = ch;
    report.out_x        = rx;
    report.out_y        = ry;
    report.out_z        = rz;
    report.report_count = (ch == KIND_GYRO) ? gcnt : acnt;
    report.last_report  = (ch == KIND_ACCEL) || !(smp.sample_ok && a_due);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      ch           <= KIND_GYRO;
      div_cnt      <= '0;
      mstep        <= '0;
      gyro_enable  <= 1'b0;
      accel_enable <= 1'b0;
      gyro_rps     <= 16'd10;
      accel_rps    <= 16'd10;
      scale_x      <= 16'd4915;
      scale_y      <= 16'd3277;
      gdl          <= '0;
      adl          <= '0;
      gcnt         <= '0;
      acnt         <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_IDLE: begin
          if (sample_valid) begin
            // Latch the sample, drop disabled deadlines, decide who is due.
            smp   <= sample;
            ch    <= KIND_GYRO;
            if (!gyro_enable) gdl <= '0;
            if (!accel_enable) adl <= '0;
            g_due <= gyro_enable && (gdl == '0 || sample.now_us >= gdl);
            a_due <= accel_enable && (adl == '0 || sample.now_us >= adl);
          end
        end
        ST_CHAN: begin
          mstep <= '0;
          if (cur_due) begin
            div_d   <= PERIOD_NUM_ALIGNED;
            div_rem <= '0;
            div_q   <= '0;
            div_div <= PW'(clamped);
            div_cnt <= CNTW'(PNW);
          end
        end
        ST_PDIV: begin
          div_d   <= div_d << 1;
          div_rem <= rem_next;
          div_q   <= q_next;
          div_cnt <= div_cnt - CNTW'(1);
          if (div_cnt == CNTW'(1)) begin
            per <= per_next;
            if (cur_dl == '0) begin
              // Unscheduled: first deadline one period out.
              if (ch == KIND_GYRO) gdl <= smp.now_us + TW'(per_next);
              else adl <= smp.now_us + TW'(per_next);
            end else if (cur_late) begin
              // Late: remainder of (now - deadline) by the period.
              div_d   <= smp.now_us - cur_dl;
              div_rem <= '0;
              div_div <= per_next;
              div_cnt <= CNTW'(TW);
            end
          end
        end
        ST_RDIV: begin
          div_d   <= div_d << 1;
          div_rem <= rem_next;
          div_cnt <= div_cnt - CNTW'(1);
          if (div_cnt == CNTW'(1)) begin
            // Deadline + k periods equals now - remainder + period.
            if (ch == KIND_GYRO) gdl <= smp.now_us - TW'(rem_next) + TW'(per);
            else adl <= smp.now_us - TW'(rem_next) + TW'(per);
          end
        end
        ST_MUL: p_reg <= mul_a * mul_b;
        ST_ACC: begin
          mstep <= mstep + 3'd1;
          if (ch == KIND_GYRO) begin
            case (mstep)
              3'd0, 3'd2: t_reg <= p_reg[32:0];
              3'd1:       rx <= round_sat(p_reg, 1'b1);
              3'd3:       ry <= round_sat(p_reg, 1'b1);
              default:    rz <= round_sat(p_reg, 1'b0);
            endcase
          end else begin
            case (mstep)
              3'd0:    rx <= round_sat(p_reg, 1'b0);
              3'd1:    ry <= round_sat(p_reg, 1'b0);
              default: rz <= round_sat(p_reg, 1'b0);
            endcase
          end
          if (mstep == last_step) begin
            if (ch == KIND_GYRO) gcnt <= gcnt + 32'd1;
            else acnt <= acnt + 32'd1;
          end
        end
        ST_OUT: ;
        ST_NEXT: if (ch == KIND_GYRO) ch <= KIND_ACCEL;
        default: ;
      endcase

      // Register writes; a defined index also clears both deadlines.
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_GYRO_ENABLE:  gyro_enable  <= cfg_data[0];
          REG_ACCEL_ENABLE: accel_enable <= cfg_data[0];
          REG_GYRO_RATE:    gyro_rps     <= cfg_data;
          REG_ACCEL_RATE:   accel_rps    <= cfg_data;
          REG_SCALE_X:      scale_x      <= cfg_data;
          REG_SCALE_Y:      scale_y      <= cfg_data;
          default: ;
        endcase
        if (cfg_index <= REG_SCALE_Y) begin
          gdl <= '0;
          adl <= '0;
        end
      end
    end
  end

  `DRMRS_ASSERT_IMP(a_no_take_while_report, report_valid, sample_stall, "sample during report")
  `DRMRS_ASSERT_NXT(a_report_once, report_valid && !report_stall, !report_valid, "report twice")
  `DRMRS_ASSERT_IMP(a_idle_div_clear, state == ST_IDLE, div_cnt == '0, "divider busy in idle")
  `DRMRS_ASSERT_IMP(a_accel_last, report_valid && report.report_kind == KIND_ACCEL, report.last_report, "accel not last")

endmodule
